### rtl/tdrf_pkg.sv
// Shared widths, kind codes and result type for the timed disk request queue.
package tdrf_pkg;

	localparam int unsigned ID_W   = 32;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned SVC_W  = 24;
	localparam int unsigned OCC_W  = 5;
	localparam int unsigned KIND_W = 2;

	localparam logic [SVC_W-1:0] SVC_RESET = 24'd2000000;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_FIND  = 2'd2,
		KIND_CHECK = 2'd3
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0]  out_id;
		logic             out_valid;
		logic             found;
		logic             due;
		logic             overflow;
		logic [OCC_W-1:0] occupancy;
	} res_t;

endpackage

### rtl/tdrf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tdrf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/tdrf_ctrl.sv
// Queue sequencer: pointers, count, ring accesses and the ID scan.
module tdrf_ctrl import tdrf_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [KIND_W-1:0]              kind,
	input  logic [ID_W-1:0]                proc_id,
	input  logic [TIME_W-1:0]              now,
	input  logic [SVC_W-1:0]               service_time,
	output logic                           ring_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ring_waddr,
	output logic [ID_W-1:0]                id_wdata,
	output logic [TIME_W-1:0]              time_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] id_raddr,
	input  logic [ID_W-1:0]                id_rdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] time_raddr,
	input  logic [TIME_W-1:0]              time_rdata,
	output res_t                           pend,
	output logic                           pend_valid,
	input  logic                           pend_take
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SCAN = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [ID_W-1:0]     id_q;
	logic [TIME_W-1:0]   now_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [TIME_W-1:0]   last_time_q;
	logic [PTR_W-1:0]    scan_ptr_q;
	logic [CNT_W-1:0]    scan_left_q;
	res_t                pend_q;
	logic                accept;
	logic [TIME_W-1:0]   push_base;
	logic [TIME_W-1:0]   push_time;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
		logic [CNT_W+OCC_W-1:0] ext;
		ext = {{OCC_W{1'b0}}, c};
		to_occ = ext[OCC_W-1:0];
	endfunction

	function automatic res_t idle_res(input logic [CNT_W-1:0] c, input logic ovf);
		res_t r;
		r           = '0;
		r.overflow  = ovf;
		r.occupancy = to_occ(c);
		idle_res    = r;
	endfunction

	function automatic res_t pop_res(input logic [ID_W-1:0] id, input logic [CNT_W-1:0] c);
		res_t r;
		r           = '0;
		r.out_id    = id;
		r.out_valid = 1'b1;
		r.occupancy = to_occ(c);
		pop_res     = r;
	endfunction

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign pend       = pend_q;
	assign pend_valid = (state_q == S_RESP);

	// newest completion time is mirrored in a register, so a push needs no read
	assign push_base  = (count_q == '0) ? now : last_time_q;
	assign push_time  = push_base + {{(TIME_W-SVC_W){1'b0}}, service_time};

	assign ring_we    = accept && (kind_t'(kind) == KIND_PUSH) && (count_q != CNT_FULL);
	assign ring_waddr = tail_q;
	assign id_wdata   = proc_id;
	assign time_wdata = push_time;
	assign id_raddr   = (state_q == S_IDLE) ? head_q : scan_ptr_q;
	assign time_raddr = head_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			id_q   <= proc_id;
			now_q  <= now;
		end
		if (ring_we) begin
			last_time_q <= push_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			pend_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind_t'(kind))
							KIND_PUSH: begin
								if (count_q == CNT_FULL) begin
									pend_q <= idle_res(count_q, 1'b1);
								end else begin
									tail_q  <= ptr_next(tail_q);
									count_q <= count_q + CNT_W'(1);
									pend_q  <= idle_res(count_q + CNT_W'(1), 1'b0);
								end
								state_q <= S_RESP;
							end
							KIND_POP, KIND_CHECK: begin
								pend_q  <= idle_res(count_q, 1'b0);
								state_q <= (count_q == '0) ? S_RESP : S_READ;
							end
							KIND_FIND: begin
								pend_q      <= idle_res(count_q, 1'b0);
								scan_ptr_q  <= ptr_next(head_q);
								scan_left_q <= count_q - CNT_W'(1);
								state_q     <= (count_q == '0) ? S_RESP : S_SCAN;
							end
							default: begin
								pend_q  <= idle_res(count_q, 1'b0);
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_READ: begin
					if (kind_q == KIND_POP) begin
						pend_q  <= pop_res(id_rdata, count_q - CNT_W'(1));
						head_q  <= ptr_next(head_q);
						count_q <= count_q - CNT_W'(1);
					end else begin
						pend_q.due <= (time_rdata == now_q);
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					// rdata holds the entry addressed in the previous cycle
					if (id_rdata == id_q) begin
						pend_q.found <= 1'b1;
						state_q      <= S_RESP;
					end else if (scan_left_q == '0) begin
						state_q <= S_RESP;
					end else begin
						scan_ptr_q  <= ptr_next(scan_ptr_q);
						scan_left_q <= scan_left_q - CNT_W'(1);
					end
				end
				S_RESP: begin
					if (pend_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/timed_disk_request_fifo_top.sv
// Top level of the timed disk request queue: config register, rings and result register.
//
//   channel  direction  handshake            beat contents
//   req      in         req_valid/req_stall  kind, proc_id, now
//   rsp      out        rsp_valid/rsp_stall  out_id, out_valid, found, due, overflow, occupancy
//   cfg      in         cfg_wr_en            cfg_wr_data (service_time)
//
// Push and empty-queue items: the result is registered on accept, going straight to the response state.
// Pop and due check: one RAM read of the head slot (S_READ) before the response state.
// Lookup: up to QUEUE_DEPTH ring entries compared, one ring entry compared per cycle.
// Reset clears pointers and count and sets the service time to 2000000; rings need no clearing.
// A held result in the output register does not block the next req beat.
module timed_disk_request_fifo_top import tdrf_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [ID_W-1:0]    proc_id,
	input  logic [TIME_W-1:0]  now,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [ID_W-1:0]    out_id,
	output logic               out_valid,
	output logic               found,
	output logic               due,
	output logic               overflow,
	output logic [OCC_W-1:0]   occupancy,
	input  logic               cfg_wr_en,
	input  logic [SVC_W-1:0]   cfg_wr_data
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	logic [SVC_W-1:0]  service_time_q;
	logic              rsp_valid_q;
	res_t              rsp_q;
	logic              ring_we;
	logic [PTR_W-1:0]  ring_waddr;
	logic [ID_W-1:0]   id_wdata;
	logic [TIME_W-1:0] time_wdata;
	logic [PTR_W-1:0]  id_raddr;
	logic [ID_W-1:0]   id_rdata;
	logic [PTR_W-1:0]  time_raddr;
	logic [TIME_W-1:0] time_rdata;
	res_t              pend;
	logic              pend_valid;
	logic              pend_take;

	assign pend_take = pend_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_time_q <= SVC_RESET;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				service_time_q <= cfg_wr_data;
			end
			if (pend_take) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_take) begin
			rsp_q <= pend;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign out_id    = rsp_q.out_id;
	assign out_valid = rsp_q.out_valid;
	assign found     = rsp_q.found;
	assign due       = rsp_q.due;
	assign overflow  = rsp_q.overflow;
	assign occupancy = rsp_q.occupancy;

	tdrf_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.proc_id     (proc_id),
		.now         (now),
		.service_time(service_time_q),
		.ring_we     (ring_we),
		.ring_waddr  (ring_waddr),
		.id_wdata    (id_wdata),
		.time_wdata  (time_wdata),
		.id_raddr    (id_raddr),
		.id_rdata    (id_rdata),
		.time_raddr  (time_raddr),
		.time_rdata  (time_rdata),
		.pend        (pend),
		.pend_valid  (pend_valid),
		.pend_take   (pend_take)
	);

	tdrf_ram #(
		.WIDTH(ID_W),
		.DEPTH(QUEUE_DEPTH)
	) u_id_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(id_wdata),
		.raddr(id_raddr),
		.rdata(id_rdata)
	);

	tdrf_ram #(
		.WIDTH(TIME_W),
		.DEPTH(QUEUE_DEPTH)
	) u_time_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(time_wdata),
		.raddr(time_raddr),
		.rdata(time_rdata)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the timed disk request queue: shadow queue, random traffic, stalls.
module tb_top;
	import tdrf_pkg::*;

	localparam int unsigned DEPTH    = 16;
	localparam int unsigned LIMIT    = 400000;
	localparam int unsigned SETTLE   = 2 + DEPTH + 6;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   proc_id;
	logic [TIME_W-1:0] now;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [ID_W-1:0]   out_id;
	logic              out_valid;
	logic              found;
	logic              due;
	logic              overflow;
	logic [OCC_W-1:0]  occupancy;
	logic              cfg_wr_en;
	logic [SVC_W-1:0]  cfg_wr_data;

	int unsigned cycle_count;
	int unsigned req_idle_pct;
	int unsigned rsp_idle_pct;
	bit          quiet;

	// Shadow of the request ring plus the replies still owed by the block.
	class request_queue_mirror;
		logic [ID_W-1:0]   id_ring[DEPTH];
		logic [TIME_W-1:0] time_ring[DEPTH];
		int unsigned       head;
		int unsigned       tail;
		int unsigned       count;
		logic [SVC_W-1:0]  service;
		res_t              awaited[$];
		int unsigned       errors;

		function new();
			head    = 0;
			tail    = 0;
			count   = 0;
			service = SVC_RESET;
			errors  = 0;
		endfunction

		function void set_service(logic [SVC_W-1:0] v);
			service = v;
		endfunction

		function logic [TIME_W-1:0] head_time();
			return time_ring[head];
		endfunction

		function logic [ID_W-1:0] held_id(int unsigned n);
			return id_ring[(head + n) % DEPTH];
		endfunction

		function void note_request(kind_t k, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
			res_t              r;
			logic [TIME_W-1:0] base;
			r = '0;
			case (k)
				KIND_PUSH: begin
					if (count >= DEPTH) begin
						r.overflow = 1'b1;
					end else begin
						// chained after the newest entry unless the queue is empty
						base = (count == 0) ? t : time_ring[(tail + DEPTH - 1) % DEPTH];
						id_ring[tail]   = id;
						time_ring[tail] = base + {{(TIME_W-SVC_W){1'b0}}, service};
						tail  = (tail + 1) % DEPTH;
						count = count + 1;
					end
				end
				KIND_POP: begin
					if (count > 0) begin
						r.out_id    = id_ring[head];
						r.out_valid = 1'b1;
						head  = (head + 1) % DEPTH;
						count = count - 1;
					end
				end
				KIND_FIND: begin
					for (int unsigned i = 0; i < count; i++)
						if (id_ring[(head + i) % DEPTH] === id)
							r.found = 1'b1;
				end
				default: begin
					r.due = (count > 0) && (time_ring[head] === t);
				end
			endcase
			r.occupancy = OCC_W'(count);
			awaited.push_back(r);
		endfunction

		function void check_reply(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				$error("reply with none outstanding: out_id %h occupancy %0d",
					got.out_id, got.occupancy);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.out_id !== want.out_id) begin
				$error("out_id: expected %h, actual %h", want.out_id, got.out_id);
				errors++;
			end
			if (got.out_valid !== want.out_valid) begin
				$error("out_valid: expected %b, actual %b", want.out_valid, got.out_valid);
				errors++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %b, actual %b", want.found, got.found);
				errors++;
			end
			if (got.due !== want.due) begin
				$error("due: expected %b, actual %b", want.due, got.due);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %b, actual %b", want.overflow, got.overflow);
				errors++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
				errors++;
			end
		endfunction
	endclass

	request_queue_mirror mirror = new;

	timed_disk_request_fifo_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.proc_id    (proc_id),
		.now        (now),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.out_id     (out_id),
		.out_valid  (out_valid),
		.found      (found),
		.due        (due),
		.overflow   (overflow),
		.occupancy  (occupancy),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Reply side: random back-pressure, checked on every accepted beat.
	always @(negedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(0, 99) < rsp_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			mirror.check_reply({out_id, out_valid, found, due, overflow, occupancy});
	end

	// Entered and left at a falling edge; valid stays up after acceptance until
	// the next call either idles or presents the following beat.
	task automatic send_request(input kind_t k, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] t);
		while (!quiet && ($urandom_range(0, 99) < req_idle_pct)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		proc_id   <= id;
		now       <= t;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
		mirror.note_request(k, id, t);
		@(negedge clk);
	endtask

	task automatic write_service(input logic [SVC_W-1:0] v);
		req_valid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mirror.set_service(v);
	endtask

	task automatic random_request(input bit filling);
		kind_t             k;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] t;
		int unsigned       r;
		r = $urandom_range(0, 99);
		if (filling)
			k = (r < 55) ? KIND_PUSH : (r < 70) ? KIND_POP : (r < 85) ? KIND_FIND : KIND_CHECK;
		else
			k = (r < 20) ? KIND_PUSH : (r < 65) ? KIND_POP : (r < 82) ? KIND_FIND : KIND_CHECK;
		// a small id pool makes duplicates and lookup hits likely
		id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
		if ($urandom_range(0, 4) == 0)
			t = TIME_MAX - TIME_W'($urandom_range(0, 1 << 25));
		else
			t = TIME_W'({$urandom, $urandom});
		if (k == KIND_FIND && mirror.count > 0 && $urandom_range(0, 1) == 1)
			id = mirror.held_id($urandom_range(0, mirror.count - 1));
		if (k == KIND_CHECK && mirror.count > 0) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				t = mirror.head_time();
			else if (r == 5)
				t = mirror.head_time() + 1'b1;
			else if (r == 6)
				t = mirror.head_time() - 1'b1;
		end
		send_request(k, id, t);
	endtask

	initial begin
		logic [SVC_W-1:0] svc_next;
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		kind         = KIND_PUSH;
		proc_id      = '0;
		now          = '0;
		rsp_stall    = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		cycle_count  = 0;
		quiet        = 1'b0;
		req_idle_pct = 11;
		rsp_idle_pct = 46;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty queue, wrapped completion time, full ring, deepest lookup
		send_request(KIND_POP, '0, '0);
		send_request(KIND_CHECK, '0, '0);
		send_request(KIND_FIND, '0, '0);
		send_request(KIND_PUSH, '1, TIME_MAX);
		send_request(KIND_CHECK, '0, mirror.head_time());
		send_request(KIND_FIND, '1, '0);
		send_request(KIND_FIND, '0, TIME_MAX);
		for (int i = 0; i < DEPTH - 1; i++)
			send_request(KIND_PUSH, (i == DEPTH - 2) ? '0 : (ID_W'($urandom) | 1'b1),
				TIME_W'({$urandom, $urandom}));
		send_request(KIND_PUSH, 32'h0000_1234, '0);
		send_request(KIND_FIND, '0, '0);
		send_request(KIND_CHECK, '0, mirror.head_time() + 1'b1);
		send_request(KIND_POP, '0, '0);

		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: svc_next = '0;
				1: svc_next = '1;
				3: svc_next = 24'd1;
				5: svc_next = SVC_RESET;
				default: svc_next = SVC_W'($urandom);
			endcase
			write_service(svc_next);
			req_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 46 : 0;
			rsp_idle_pct = (seg < 2) ? 46 : (seg < 4) ? 11 : 0;
			for (int n = 0; n < 155; n++) begin
				quiet = (n % 64) >= 48;
				random_request(((n / 40) % 2) == 0);
			end
			quiet = 1'b0;
		end

		req_valid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mirror.errors == 0 && mirror.awaited.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
